// ===== rtl/nsh_pkg.sv =====
// Package with payload types, state codes and command structs for nearest_segment_hit.
package nsh_pkg;

   localparam int unsigned COORD_WIDTH = 16;
   localparam int unsigned DIFF_WIDTH = 17;
   localparam int unsigned CROSS_WIDTH = 35;
   localparam int unsigned DIST_WIDTH = 34;
   localparam int unsigned RATIO_BITS = 16;
   localparam logic KIND_RAY = 1'b0;
   localparam logic KIND_SEGMENT = 1'b1;

   typedef struct packed {
      logic kind;
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic last;
   } req_type;

   typedef struct packed {
      logic hit;
      logic signed [COORD_WIDTH-1:0] hit_x;
      logic signed [COORD_WIDTH-1:0] hit_y;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIFF  = 7'b0000010,
      ST_CROSS = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_POINT = 7'b0100000,
      ST_DIST  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load_ray;
      logic load_seg;
      logic do_diff;
      logic do_cross;
      logic do_check;
      logic div_step;
      logic do_point;
      logic do_dist;
   } cmd_type;

   typedef struct packed {
      logic candidate;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/nearest_segment_hit.sv =====
// A ray request only loads the ray and clears the best hit; a segment request goes
// through diff, cross and check, and on a hit candidate also div, point and dist.
// Throughput: one request at a time; the next is taken once the previous finishes
// and any pending response has been taken. Synchronous active-high reset clears
// the controller, the ray-best state and the response valid.
// Top level of the nearest wall segment hit block.
module nearest_segment_hit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nsh_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nsh_pkg::rsp_type rsp_data
);

   nsh_pkg::cmd_type cmd;
   nsh_pkg::status_type status;

   nsh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .status(status)
   );

   nsh_datapath u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .status(status), .rsp_data(rsp_data)
   );

endmodule

// ===== rtl/nsh_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module nsh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nsh_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output nsh_pkg::cmd_type   cmd,
   input  nsh_pkg::status_type status
);

   nsh_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == nsh_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         nsh_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == nsh_pkg::KIND_RAY) begin
                  cmd.load_ray = 1'b1;
               end else begin
                  cmd.load_seg = 1'b1;
                  last_in = req_data.last;
                  state_in = nsh_pkg::ST_DIFF;
               end
            end
         end
         nsh_pkg::ST_DIFF: begin
            cmd.do_diff = 1'b1;
            state_in = nsh_pkg::ST_CROSS;
         end
         nsh_pkg::ST_CROSS: begin
            cmd.do_cross = 1'b1;
            state_in = nsh_pkg::ST_CHECK;
         end
         nsh_pkg::ST_CHECK: begin
            cmd.do_check = 1'b1;
            if (status.candidate) begin
               state_in = nsh_pkg::ST_DIV;
            end else begin
               state_in = nsh_pkg::ST_IDLE;
               rsp_valid_in = last_ff;
            end
         end
         nsh_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = nsh_pkg::ST_POINT;
            end
         end
         nsh_pkg::ST_POINT: begin
            cmd.do_point = 1'b1;
            state_in = nsh_pkg::ST_DIST;
         end
         nsh_pkg::ST_DIST: begin
            cmd.do_dist = 1'b1;
            state_in = nsh_pkg::ST_IDLE;
            rsp_valid_in = last_ff;
         end
         default: begin
            state_in = nsh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nsh_pkg::ST_IDLE;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/nsh_datapath.sv =====
// Datapath with ray state, cross products, serial divider and best-hit tracking.
module nsh_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  nsh_pkg::req_type     req_data,
   input  nsh_pkg::cmd_type     cmd,
   output nsh_pkg::status_type  status,
   output nsh_pkg::rsp_type     rsp_data
);

   localparam int unsigned DW = nsh_pkg::DIFF_WIDTH;
   localparam int unsigned CW = nsh_pkg::CROSS_WIDTH;
   localparam int unsigned RB = nsh_pkg::RATIO_BITS;
   localparam int unsigned SW = nsh_pkg::DIST_WIDTH;
   localparam int unsigned PW = DW + RB + 1;
   localparam int unsigned CNT_W = $clog2(RB + 1);

   logic signed [15:0] rsx_ff, rsy_ff, rex_ff, rey_ff;
   logic signed [15:0] ssx_ff, ssy_ff, sex_ff, sey_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, lx_ff, ly_ff, wx_ff, wy_ff;
   logic signed [CW-1:0] c_ff, na_ff, nb_ff;
   logic [CW-1:0] cpos_ff, rem_ff;
   logic [RB-1:0] aq_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [15:0] px_ff, py_ff;
   logic signed [DW-1:0] ox_ff, oy_ff;
   logic [SW-1:0] best_d_ff;
   logic signed [15:0] best_x_ff, best_y_ff;
   logic found_ff;

   logic neg;
   logic signed [CW-1:0] cabs, naa, nba;
   logic cand;
   logic [CW:0] rem_sh, rem_sub;
   logic signed [PW-1:0] mx, my;
   logic signed [PW-RB-1:0] fx, fy;
   logic [SW-1:0] dist_sq;
   logic [SW-1:0] sqx, sqy;

   assign neg = c_ff[CW-1];
   assign cabs = neg ? -c_ff : c_ff;
   assign naa = neg ? -na_ff : na_ff;
   assign nba = neg ? -nb_ff : nb_ff;
   assign cand = (c_ff != '0) && (naa > 0) && (naa < cabs) && (nba > 0) && (nba < cabs);
   assign status.candidate = cand;
   assign status.div_done = (cnt_ff == CNT_W'(1));

   assign rem_sh = {rem_ff, 1'b0};
   assign rem_sub = rem_sh - {1'b0, cpos_ff};

   assign mx = PW'(dx_ff) * $signed({1'b0, aq_ff});
   assign my = PW'(dy_ff) * $signed({1'b0, aq_ff});
   assign fx = mx[PW-1:RB];
   assign fy = my[PW-1:RB];

   assign sqx = SW'(ox_ff * ox_ff);
   assign sqy = SW'(oy_ff * oy_ff);
   assign dist_sq = sqx + sqy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsx_ff <= '0;
         rsy_ff <= '0;
         rex_ff <= '0;
         rey_ff <= '0;
      end else if (cmd.load_ray) begin
         rsx_ff <= req_data.first_x;
         rsy_ff <= req_data.first_y;
         rex_ff <= req_data.second_x;
         rey_ff <= req_data.second_y;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_seg) begin
         ssx_ff <= req_data.first_x;
         ssy_ff <= req_data.first_y;
         sex_ff <= req_data.second_x;
         sey_ff <= req_data.second_y;
      end
      if (cmd.do_diff) begin
         dx_ff <= DW'(rex_ff) - DW'(rsx_ff);
         dy_ff <= DW'(rey_ff) - DW'(rsy_ff);
         lx_ff <= DW'(sex_ff) - DW'(ssx_ff);
         ly_ff <= DW'(sey_ff) - DW'(ssy_ff);
         wx_ff <= DW'(ssx_ff) - DW'(rsx_ff);
         wy_ff <= DW'(ssy_ff) - DW'(rsy_ff);
      end
      if (cmd.do_cross) begin
         c_ff <= CW'(dx_ff * ly_ff) - CW'(dy_ff * lx_ff);
         na_ff <= CW'(wx_ff * ly_ff) - CW'(wy_ff * lx_ff);
         nb_ff <= CW'(wx_ff * dy_ff) - CW'(wy_ff * dx_ff);
      end
      if (cmd.do_check) begin
         cpos_ff <= cabs;
         rem_ff <= naa;
         aq_ff <= '0;
         cnt_ff <= CNT_W'(RB);
      end
      if (cmd.div_step) begin
         if (!rem_sub[CW]) begin
            rem_ff <= rem_sub[CW-1:0];
            aq_ff <= {aq_ff[RB-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[CW-1:0];
            aq_ff <= {aq_ff[RB-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.do_point) begin
         px_ff <= rsx_ff + 16'(fx);
         py_ff <= rsy_ff + 16'(fy);
         ox_ff <= DW'(fx);
         oy_ff <= DW'(fy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_ray) begin
         best_d_ff <= '1;
         best_x_ff <= '0;
         best_y_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.do_dist && (dist_sq < best_d_ff)) begin
         best_d_ff <= dist_sq;
         best_x_ff <= px_ff;
         best_y_ff <= py_ff;
         found_ff <= 1'b1;
      end
   end

   assign rsp_data.hit = found_ff;
   assign rsp_data.hit_x = found_ff ? best_x_ff : '0;
   assign rsp_data.hit_y = found_ff ? best_y_ff : '0;

endmodule

// ===== rtl/nsh_checker.sv =====
// Port-level assertions for nearest_segment_hit and their bind.
module nsh_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input nsh_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nsh_pkg::rsp_type rsp_data
);

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.hit_x == '0 && rsp_data.hit_y == '0)
      else $error("miss response carries a nonzero point");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_busy_after_seg: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == nsh_pkg::KIND_SEGMENT |=> !req_ready)
      else $error("request taken while a segment is in work");

   a_ray_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == nsh_pkg::KIND_RAY |=> !rsp_valid)
      else $error("ray request produced a response");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind nearest_segment_hit nsh_checker u_nsh_checker (.*);

// ===== bench/nearest_segment_hit_tb.sv =====
// Self-checking testbench for the nearest wall segment hit block.
module nearest_segment_hit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   nsh_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   nsh_pkg::rsp_type rsp_data;

   logic signed [15:0] ray_sx = '0, ray_sy = '0, ray_ex = '0, ray_ey = '0;
   logic [33:0] nearest_dist_sq = '1;
   logic signed [15:0] nearest_x = '0, nearest_y = '0;
   logic hit_seen = 1'b0;

   nsh_pkg::rsp_type hits_due[$];
   int errors = 0;
   int cycles = 0;
   bit hold_off = 1'b0;
   bit stall_on = 1'b1;
   int burst_left = 0;

   nearest_segment_hit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("FAIL nearest_segment_hit");
         $finish;
      end
   end

   // Predict the effect of one accepted request.
   task automatic predict_request(input nsh_pkg::req_type r);
      logic signed [63:0] dx, dy, lx, ly, wx, wy, c, na, nb, px, py, ox, oy, pq;
      logic [63:0] aq, dist_sq;
      if (r.kind == nsh_pkg::KIND_RAY) begin
         ray_sx = r.first_x; ray_sy = r.first_y;
         ray_ex = r.second_x; ray_ey = r.second_y;
         nearest_dist_sq = '1; nearest_x = '0; nearest_y = '0; hit_seen = 1'b0;
         return;
      end
      dx = ray_ex - ray_sx; dy = ray_ey - ray_sy;
      lx = r.second_x - r.first_x; ly = r.second_y - r.first_y;
      wx = r.first_x - ray_sx; wy = r.first_y - ray_sy;
      c = dx * ly - dy * lx;
      na = wx * ly - wy * lx;
      nb = wx * dy - wy * dx;
      if (c < 0) begin
         c = -c; na = -na; nb = -nb;
      end
      if (c != 0 && na > 0 && na < c && nb > 0 && nb < c) begin
         aq = (na << nsh_pkg::RATIO_BITS) / c;
         pq = dx * $signed(aq);
         px = ray_sx + (pq >>> nsh_pkg::RATIO_BITS);
         pq = dy * $signed(aq);
         py = ray_sy + (pq >>> nsh_pkg::RATIO_BITS);
         ox = px - ray_sx; oy = py - ray_sy;
         dist_sq = ox * ox + oy * oy;
         if (dist_sq < {30'd0, nearest_dist_sq}) begin
            nearest_dist_sq = dist_sq[33:0];
            nearest_x = px[15:0]; nearest_y = py[15:0]; hit_seen = 1'b1;
         end
      end
      if (r.last)
         hits_due.push_back(nsh_pkg::rsp_type'{hit_seen, nearest_x, nearest_y});
   endtask

   task automatic send_request(input nsh_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset)
         rsp_ready <= !hold_off && (!stall_on || $urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      nsh_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hits_due.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            want = hits_due.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.hit_x !== want.hit_x
                  || rsp_data.hit_y !== want.hit_y) begin
               $display("%0t: expected %h actual %h", $time, want, rsp_data);
               errors++;
            end
         end
      end
   end

   function automatic nsh_pkg::req_type make_request(logic kind, logic [15:0] a,
         logic [15:0] b, logic [15:0] c, logic [15:0] d, logic last);
      return '{kind, a, b, c, d, last};
   endfunction

   function automatic logic [15:0] rand_coord();
      return $urandom_range(0, 3) == 0 ? 16'($urandom)
         : 16'($signed($urandom_range(0, 8192)) - 4096);
   endfunction

   function automatic nsh_pkg::req_type rand_segment(logic last);
      logic [15:0] mx, my;
      mx = rand_coord(); my = rand_coord();
      return make_request(nsh_pkg::KIND_SEGMENT, mx, my,
         16'($urandom_range(0, 1) ? -mx : rand_coord()),
         16'($urandom_range(0, 1) ? -my : rand_coord()), last);
   endfunction

   task automatic test_directed();
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0100, 16'hff00, 16'h0100, 16'h0100, 1'b1));
      send_request(make_request(nsh_pkg::KIND_RAY, 16'h0000, 16'h0000, 16'h0400, 16'h0000, 1'b1));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0200, 16'hff00, 16'h0200, 16'h0100, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0100, 16'hff00, 16'h0100, 16'h0100, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0100, 16'hff00, 16'h0100, 16'h0100, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0000, 16'h0100, 16'h0400, 16'h0100, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0400, 16'hff00, 16'h0400, 16'h0100, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0300, 16'h0000, 16'h0300, 16'h0100, 1'b1));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0080, 16'hff00, 16'h0080, 16'h0100, 1'b1));
      send_request(make_request(nsh_pkg::KIND_RAY, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b1));
      send_request(make_request(nsh_pkg::KIND_RAY, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_request(make_request(nsh_pkg::KIND_RAY, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b0));
      send_request(make_request(nsh_pkg::KIND_SEGMENT, 16'h0000, 16'h0000, 16'h0200, 16'h0200, 1'b1));
   endtask

   task automatic test_random(input int count);
      int segs;
      for (int n = 0; n < count;) begin
         send_request(make_request(nsh_pkg::KIND_RAY, rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), 1'($urandom)));
         segs = $urandom_range(1, 8);
         n += segs + 1;
         for (int s = 1; s <= segs; s++)
            send_request(rand_segment(s == segs || $urandom_range(0, 9) == 0));
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            send_request(make_request(nsh_pkg::KIND_RAY, 16'h0000, 16'h0000, 16'h0800,
               16'h0800, 1'b0));
            for (int s = 0; s < 12; s++)
               send_request(rand_segment(1'b1));
         end
      join
      stall_on = 1'b0;
      test_random(450);
      stall_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(450);
      req_valid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && hits_due.size() == 0)
         $display("PASS nearest_segment_hit");
      else
         $display("FAIL nearest_segment_hit");
      $finish;
   end
endmodule

// ===== nearest_segment_hit.f =====
rtl/nsh_pkg.sv
rtl/nsh_ctrl.sv
rtl/nsh_datapath.sv
rtl/nearest_segment_hit.sv
rtl/nsh_checker.sv
bench/nearest_segment_hit_tb.sv
